// File: rtl/mexp_pkg.sv
// Shared types and constants for the modular exponentiation block.
// No dependencies; used by every module under rtl/.
package mexp_pkg;

    localparam int OPERAND_WIDTH = 32;
    localparam int PORT_WIDTH    = 32;
    localparam int PROD_WIDTH    = 2 * OPERAND_WIDTH;
    localparam int CNT_WIDTH     = $clog2(PROD_WIDTH + 1);

    typedef logic [OPERAND_WIDTH-1:0] operand_t;
    typedef logic [PROD_WIDTH-1:0]    product_t;
    typedef logic [CNT_WIDTH-1:0]     count_t;

    typedef struct packed {
        logic load;       // latch operands of the accepted word
        logic init_acc;   // acc <= 1 mod m
        logic start_a;    // lane A: acc * pw mod m
        logic start_b;    // lane B: pw * pw (or pw * 1) mod m
        logic sel_one;    // lane B second operand is 1
        logic take_pw;    // pw <= lane B result
        logic update;     // one exponent bit done
        logic publish;    // load output register
    } cmd_t;

    typedef struct packed {
        logic mod_zero;
        logic expo_zero;
        logic a_done;
        logic b_done;
        logic out_free;
    } status_t;

endpackage

// File: rtl/mexp_mulmod.sv
// Sequential modular multiplier: one registered multiply, then a restoring
// remainder over the product, one bit per cycle. Depends on mexp_pkg.
module mexp_mulmod
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  mexp_pkg::operand_t a,
    input  mexp_pkg::operand_t b,
    input  mexp_pkg::operand_t m,
    output logic               done,
    output mexp_pkg::operand_t result
);

    mexp_pkg::product_t prod_reg, prod_next;
    mexp_pkg::operand_t rem_reg, rem_next;
    mexp_pkg::count_t   cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;

    logic [mexp_pkg::OPERAND_WIDTH:0] trial;
    logic [mexp_pkg::OPERAND_WIDTH:0] diff;

    assign trial = {rem_reg, prod_reg[mexp_pkg::PROD_WIDTH-1]};
    assign diff  = trial - {1'b0, m};

    always_comb
    begin
        prod_next = prod_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            prod_next = mexp_pkg::PROD_WIDTH'(a) * mexp_pkg::PROD_WIDTH'(b);
            rem_next  = '0;
            cnt_next  = mexp_pkg::CNT_WIDTH'(mexp_pkg::PROD_WIDTH);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            prod_next = {prod_reg[mexp_pkg::PROD_WIDTH-2:0], 1'b0};
            if (trial >= {1'b0, m})
            begin
                rem_next = diff[mexp_pkg::OPERAND_WIDTH-1:0];
            end
            else
            begin
                rem_next = trial[mexp_pkg::OPERAND_WIDTH-1:0];
            end
            cnt_next = cnt_reg - mexp_pkg::CNT_WIDTH'(1);
            if (cnt_reg == mexp_pkg::CNT_WIDTH'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        rem_reg  <= rem_next;
    end

    assign done   = done_reg;
    assign result = rem_reg;

    a_rem_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (rem_reg < m))
        else $error("remainder not below modulus");

    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && busy_reg))
        else $error("multiplier restarted while busy");

endmodule

// File: rtl/mexp_dp.sv
// Datapath: operand, accumulator and power registers, two mulmod lanes and
// the output word register. Depends on mexp_pkg and mexp_mulmod.
module mexp_dp
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  mexp_pkg::cmd_t         cmd,
    output mexp_pkg::status_t      status,
    input  logic [3*mexp_pkg::PORT_WIDTH-1:0] in_data,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [mexp_pkg::PORT_WIDTH-1:0] m_tdata,
    output logic                   m_tuser
);

    mexp_pkg::operand_t acc_reg, pw_reg, expo_reg, mod_reg;
    logic               zero_reg;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [mexp_pkg::PORT_WIDTH-1:0] m_tdata_reg;
    logic               m_tuser_reg;

    mexp_pkg::operand_t lane_b_op;
    mexp_pkg::operand_t res_a, res_b;
    logic               done_a, done_b;

    assign lane_b_op = cmd.sel_one ? mexp_pkg::operand_t'(1) : pw_reg;

    mexp_mulmod u_lane_a
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.start_a),
        .a      (acc_reg),
        .b      (pw_reg),
        .m      (mod_reg),
        .done   (done_a),
        .result (res_a)
    );

    mexp_mulmod u_lane_b
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.start_b),
        .a      (pw_reg),
        .b      (lane_b_op),
        .m      (mod_reg),
        .done   (done_b),
        .result (res_b)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            pw_reg   <= mexp_pkg::operand_t'(in_data[mexp_pkg::PORT_WIDTH-1:0]);
            expo_reg <= mexp_pkg::operand_t'(in_data[2*mexp_pkg::PORT_WIDTH-1:
                                                     mexp_pkg::PORT_WIDTH]);
            mod_reg  <= mexp_pkg::operand_t'(in_data[3*mexp_pkg::PORT_WIDTH-1:
                                                     2*mexp_pkg::PORT_WIDTH]);
            zero_reg <= (mexp_pkg::operand_t'(in_data[3*mexp_pkg::PORT_WIDTH-1:
                                                      2*mexp_pkg::PORT_WIDTH]) == '0);
        end
        else if (cmd.take_pw)
        begin
            pw_reg <= res_b;
        end
        else if (cmd.update)
        begin
            pw_reg   <= res_b;
            expo_reg <= expo_reg >> 1;
        end

        if (cmd.init_acc)
        begin
            acc_reg <= (mod_reg == mexp_pkg::operand_t'(1)) ? '0 : mexp_pkg::operand_t'(1);
        end
        else if (cmd.update && expo_reg[0])
        begin
            acc_reg <= res_a;
        end

        if (cmd.publish)
        begin
            m_tdata_reg <= zero_reg ? '0 : mexp_pkg::PORT_WIDTH'(acc_reg);
            m_tuser_reg <= zero_reg;
        end
    end

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.publish)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign status.mod_zero  = zero_reg;
    assign status.expo_zero = (expo_reg == '0);
    assign status.a_done    = done_a;
    assign status.b_done    = done_b;
    assign status.out_free  = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.publish |-> (!m_tvalid_reg || m_tready))
        else $error("output word overwritten");

    a_lanes_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.update |-> (done_a && done_b))
        else $error("bit update before both lanes finished");

endmodule

// File: rtl/mexp_ctrl.sv
// Controller: sequences operand load, base reduction and the exponent bit
// loop. Depends on mexp_pkg.
module mexp_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  mexp_pkg::status_t status,
    output mexp_pkg::cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_CHECK    = 3'd1;
    localparam logic [2:0] ST_RED_WAIT = 3'd2;
    localparam logic [2:0] ST_LOOP     = 3'd3;
    localparam logic [2:0] ST_MUL_WAIT = 3'd4;
    localparam logic [2:0] ST_FINISH   = 3'd5;

    logic [2:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (status.mod_zero)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    cmd.init_acc = 1'b1;
                    cmd.start_b  = 1'b1;
                    cmd.sel_one  = 1'b1;
                    state_next   = ST_RED_WAIT;
                end
            end
            ST_RED_WAIT:
            begin
                if (status.b_done)
                begin
                    cmd.take_pw = 1'b1;
                    state_next  = ST_LOOP;
                end
            end
            ST_LOOP:
            begin
                if (status.expo_zero)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    cmd.start_a = 1'b1;
                    cmd.start_b = 1'b1;
                    state_next  = ST_MUL_WAIT;
                end
            end
            ST_MUL_WAIT:
            begin
                if (status.a_done && status.b_done)
                begin
                    cmd.update = 1'b1;
                    state_next = ST_LOOP;
                end
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.publish = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: rtl/modular_exponentiation_top.sv
// Channel   Dir  Bits  Contents
// s_axis    in   96    tdata: base_value[31:0], exponent_value[63:32], modulus_value[95:64]
// m_axis    out  32+1  tdata: power_result[31:0]; tuser: modulus_error
//
// One word in flight. Each word runs a base reduction, then one pair of lane
// multiplies per exponent bit up to the highest set bit, each using the
// 64-step restoring remainder in a mulmod lane; a zero modulus skips to publication.
// Reset: rst_n asynchronous, active low; clears controller and valid flags.
// A stalled m_tready holds the result in the output register; the next word is
// still accepted and computed, and waits only at publication.
// Depends on mexp_pkg, mexp_ctrl, mexp_dp, mexp_mulmod.
module modular_exponentiation_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // base_value, exponent_value, modulus_value
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // power_result
    output logic        m_tuser    // modulus_error
);

    mexp_pkg::cmd_t    cmd;
    mexp_pkg::status_t status;

    mexp_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    mexp_dp u_dp
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .status   (status),
        .in_data  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
